// ===== rtl/cnb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnb_pkg: shared types and constants
// Transaction payload structs and request codes for the naive Bayes block.
// ----------------------------------------------------------------------------
package cnb_pkg;

  localparam int FRAC_BITS = 48;
  localparam int NCELLS    = 9;

  localparam logic [1:0] REQ_TRAIN   = 2'd0;
  localparam logic [1:0] REQ_PREDICT = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  localparam logic [1:0] VAL_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] cell_0;
    logic [1:0] cell_1;
    logic [1:0] cell_2;
    logic [1:0] cell_3;
    logic [1:0] cell_4;
    logic [1:0] cell_5;
    logic [1:0] cell_6;
    logic [1:0] cell_7;
    logic [1:0] cell_8;
    logic       sample_label;
  } in_item_t;

  typedef struct packed {
    logic        predicted_class;
    logic [47:0] posterior;
    logic        accepted;
  } out_item_t;

  // Control to the arithmetic unit.
  typedef struct packed {
    logic start_div;
    logic start_mul;
  } au_ctl_t;

  typedef struct packed {
    logic busy;
  } au_sts_t;

endpackage
`default_nettype wire

// ===== rtl/categorical_naive_bayes_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// categorical_naive_bayes_classifier: two-class naive Bayes over nine cells
//
// Input channel in_valid/in_stall/in_data carries one request transaction:
// train, predict or clear. Each request returns exactly one transaction on
// out_valid/out_stall/out_data. The block works on one request at a time and
// holds in_stall high from acceptance until the result moves into the output
// register. A result waiting there does not block the next request.
// Clear, a refused train, predict with no samples and the unused request
// code go straight to the output push. An accepted train does a read and a
// write of the cell counter memory per cell. Predict does, per class, one
// prior division, nine likelihood divisions and nine multiplications, with
// start and compare steps. When one class holds every sample its prior
// saturates at once without a division. Reset clears the class counts and
// the cell counter valid flags, so every cell counter reads as zero until
// written. When the receiver stalls, hold the result in the output
// register; a second finished result waits inside.
// ----------------------------------------------------------------------------
module categorical_naive_bayes_classifier #(
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cnb_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cnb_pkg::out_item_t      out_data
);
  import cnb_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 4);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRIOR = 4'd1;
  localparam logic [3:0] S_LIK   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_WAIT  = 4'd4;
  localparam logic [3:0] S_OUT   = 4'd5;
  localparam logic [3:0] S_TRD   = 4'd6;
  localparam logic [3:0] S_TWR   = 4'd7;
  localparam logic [3:0] S_PUSH  = 4'd8;

  logic [CW-1:0] cls_cnt_r [2];
  logic [CW-1:0] cvc_mem [54];
  logic [53:0]   cvc_vld_r;
  logic [CW-1:0] cvc_q_r;
  logic          cvc_vq_r;
  logic [CW-1:0] cvc_cur;
  logic          cvc_we;
  logic          cls_inc;
  logic          do_clear;

  logic [3:0]  state_r, state_nxt;
  logic [3:0]  ret_r, ret_nxt;
  logic        cls_r, cls_nxt;
  logic [3:0]  cell_r, cell_nxt;
  logic [47:0] post_r, post_nxt, post0_r, post0_nxt;
  logic [1:0]  vals_r [9];
  out_item_t   wrk_r, wrk_nxt;
  out_item_t   res_r, res_nxt;
  logic        ov_r, ov_nxt;

  au_ctl_t       au_ctl;
  au_sts_t       au_sts;
  logic [CW-1:0] au_num, au_den;
  logic [47:0]   au_res;

  logic [1:0]    vin [9];
  logic [CW:0]   total;
  logic [3:0]    cell_ix;
  logic [5:0]    idx;

  function automatic logic [1:0] fix_val(input logic [1:0] v);
    return (v == 2'd3) ? VAL_EMPTY : v;
  endfunction

  assign vin[0] = fix_val(in_data.cell_0);
  assign vin[1] = fix_val(in_data.cell_1);
  assign vin[2] = fix_val(in_data.cell_2);
  assign vin[3] = fix_val(in_data.cell_3);
  assign vin[4] = fix_val(in_data.cell_4);
  assign vin[5] = fix_val(in_data.cell_5);
  assign vin[6] = fix_val(in_data.cell_6);
  assign vin[7] = fix_val(in_data.cell_7);
  assign vin[8] = fix_val(in_data.cell_8);

  assign total = {1'b0, cls_cnt_r[0]} + {1'b0, cls_cnt_r[1]};
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = res_r;

  // index of the current cell counter for the active class
  assign cell_ix = (cell_r < 4'(NCELLS)) ? cell_r : 4'd0;
  assign idx = 6'(cell_ix) * 6'd6 + 6'(vals_r[cell_ix]) * 6'd2 + 6'(cls_r);

  // counters never written since reset or clear read as zero
  assign cvc_cur = cvc_vq_r ? cvc_q_r : '0;

  cnb_arith #(.CW(CW)) u_arith (
    .clk(clk), .rst_n(rst_n), .ctl(au_ctl), .num(au_num), .den(au_den),
    .mul_a(post_r), .mul_b(au_res), .sts(au_sts), .result(au_res)
  );

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cls_nxt   = cls_r;
    cell_nxt  = cell_r;
    post_nxt  = post_r;
    post0_nxt = post0_r;
    wrk_nxt   = wrk_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r;
    au_ctl    = '0;
    au_num    = '0;
    au_den    = '0;
    cvc_we    = 1'b0;
    cls_inc   = 1'b0;
    do_clear  = 1'b0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          wrk_nxt   = '{predicted_class: 1'b0, posterior: '0, accepted: 1'b1};
          state_nxt = S_PUSH;
          case (in_data.req_type)
            REQ_TRAIN: begin
              if (total >= (CW+1)'(MAX_SAMPLES)) begin
                wrk_nxt.accepted = 1'b0;
              end else begin
                cls_nxt   = in_data.sample_label;
                cell_nxt  = '0;
                state_nxt = S_TRD;
              end
            end
            REQ_PREDICT: begin
              if (total == '0) begin
                wrk_nxt.predicted_class = 1'b1;
              end else begin
                cls_nxt   = 1'b0;
                state_nxt = S_PRIOR;
              end
            end
            REQ_CLEAR: do_clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_TRD: begin
        // counter read lands at this edge
        state_nxt = S_TWR;
      end
      S_TWR: begin
        cvc_we   = 1'b1;
        cell_nxt = cell_r + 4'd1;
        if (cell_r == 4'(NCELLS - 1)) begin
          cls_inc   = 1'b1;
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_TRD;
        end
      end
      S_PRIOR: begin
        // prior = class count / total
        au_ctl.start_div = 1'b1;
        au_num = cls_cnt_r[cls_r];
        au_den = total[CW-1:0];
        cell_nxt  = '0;
        ret_nxt   = S_LIK;
        state_nxt = S_WAIT;
      end
      S_LIK: begin
        post_nxt = au_res;
        if (cell_r == 4'd0 && ret_r == S_LIK) post_nxt = au_res;
        au_ctl.start_div = 1'b1;
        au_num = cvc_cur + CW'(1);
        au_den = cls_cnt_r[cls_r] + CW'(3);
        ret_nxt   = S_MUL;
        state_nxt = S_WAIT;
      end
      S_MUL: begin
        au_ctl.start_mul = 1'b1;
        cell_nxt  = cell_r + 4'd1;
        ret_nxt   = (cell_r == 4'(NCELLS - 1)) ? S_OUT : S_LIK;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!au_sts.busy && !au_ctl.start_div) begin
          state_nxt = ret_r;
          if (ret_r == S_LIK && cell_r != 4'd0) post_nxt = au_res;
        end
      end
      S_OUT: begin
        // au_res holds the finished class posterior
        if (!cls_r) begin
          post0_nxt = au_res;
          cls_nxt   = 1'b1;
          state_nxt = S_PRIOR;
        end else begin
          if (post0_r > au_res) begin
            wrk_nxt.predicted_class = 1'b0;
            wrk_nxt.posterior       = post0_r;
          end else begin
            wrk_nxt.predicted_class = 1'b1;
            wrk_nxt.posterior       = au_res;
          end
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        // hold the result until the output register is free
        if (!ov_r || !out_stall) begin
          res_nxt   = wrk_r;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cvc_we) cvc_mem[idx] <= cvc_cur + CW'(1);
    cvc_q_r  <= cvc_mem[idx];
    cvc_vq_r <= cvc_vld_r[idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ov_r         <= 1'b0;
      cls_cnt_r[0] <= '0;
      cls_cnt_r[1] <= '0;
      cvc_vld_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (do_clear) begin
        cls_cnt_r[0] <= '0;
        cls_cnt_r[1] <= '0;
        cvc_vld_r    <= '0;
      end
      if (cls_inc) cls_cnt_r[cls_r] <= cls_cnt_r[cls_r] + CW'(1);
      if (cvc_we) cvc_vld_r[idx] <= 1'b1;
    end
    ret_r   <= ret_nxt;
    cls_r   <= cls_nxt;
    cell_r  <= cell_nxt;
    post_r  <= post_nxt;
    post0_r <= post0_nxt;
    wrk_r   <= wrk_nxt;
    res_r   <= res_nxt;
    if (state_r == S_IDLE && in_valid && !in_stall) begin
      for (int i = 0; i < 9; i++) vals_r[i] <= vin[i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cnb_arith.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnb_arith: shared fraction divider and multiplier
// Restoring divider (one quotient bit a cycle) and a 24x24 partial-product
// multiplier (one partial product a cycle) for 48-bit fixed-point values.
// ----------------------------------------------------------------------------
module cnb_arith #(
  parameter int CW = 17
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cnb_pkg::au_ctl_t ctl,
  input  wire logic [CW-1:0]   num,
  input  wire logic [CW-1:0]   den,
  input  wire logic [47:0]     mul_a,
  input  wire logic [47:0]     mul_b,
  output cnb_pkg::au_sts_t     sts,
  output logic [47:0]          result
);
  import cnb_pkg::*;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_DIV  = 2'd1;
  localparam logic [1:0] M_MUL  = 2'd2;

  logic [1:0]    mode_r, mode_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [CW:0]   rem_r, rem_nxt;
  logic [CW-1:0] den_r, den_nxt;
  logic [47:0]   q_r, q_nxt;
  logic [47:0]   a_r, a_nxt, b_r, b_nxt;
  logic [97:0]   acc_r, acc_nxt;
  logic [CW:0]   rem_sh;
  logic [23:0]   pa, pb;
  logic [47:0]   prod;

  assign sts.busy = (mode_r != M_IDLE);
  assign result   = q_r;

  always_comb begin
    rem_sh = {rem_r[CW-1:0], 1'b0};
    pa = cnt_r[1] ? a_r[47:24] : a_r[23:0];
    pb = cnt_r[0] ? b_r[47:24] : b_r[23:0];
    prod = 48'(pa) * 48'(pb);
  end

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    case (mode_r)
      M_IDLE: begin
        if (ctl.start_div) begin
          if (den == '0 || num >= den) begin
            q_nxt = '1;
          end else begin
            rem_nxt  = {1'b0, num};
            den_nxt  = den;
            q_nxt    = '0;
            cnt_nxt  = '0;
            mode_nxt = M_DIV;
          end
        end else if (ctl.start_mul) begin
          a_nxt    = mul_a;
          b_nxt    = mul_b;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          mode_nxt = M_MUL;
        end
      end
      M_DIV: begin
        // one quotient bit per cycle
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = rem_sh - {1'b0, den_r};
          q_nxt   = {q_r[46:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          q_nxt   = {q_r[46:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(FRAC_BITS - 1)) mode_nxt = M_IDLE;
      end
      M_MUL: begin
        // accumulate partial products, weight by half indexes
        acc_nxt = acc_r + (98'(prod) << (6'd24 * (6'(cnt_r[1]) + 6'(cnt_r[0]))));
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd3) begin
          mode_nxt = M_IDLE;
          q_nxt    = acc_nxt[95:48];
        end
      end
      default: mode_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      cnt_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

endmodule
`default_nettype wire
